>>> hdl/tsr_pkg.sv
// Shared types and constants of the TCP segment reassembler.
`default_nettype none
package tsr_pkg;

  localparam int unsigned CFG_IDX_BITS = 8;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_SIZE = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_START_SEQ   = 8'd1;
  localparam logic [29:0] WINDOW_RESET = 30'd65535;
  localparam logic [31:0] LOW32_MASK   = 32'hffff_ffff;

  typedef enum logic [2:0] {
    KIND_BELOW    = 3'd0,
    KIND_ABOVE    = 3'd1,
    KIND_FULL     = 3'd2,
    KIND_COVERED  = 3'd3,
    KIND_DISCARD  = 3'd4,
    KIND_RELEASED = 3'd5,
    KIND_DONE     = 3'd6
  } kind_e;

  typedef enum logic [17:0] {
    S_IDLE   = 18'b000000000000000001,
    S_EXT    = 18'b000000000000000010,
    S_END    = 18'b000000000000000100,
    S_FIND   = 18'b000000000000001000,
    S_BOUND  = 18'b000000000000010000,
    S_CHECK  = 18'b000000000000100000,
    S_DISC   = 18'b000000000001000000,
    S_SHIFT  = 18'b000000000010000000,
    S_TRIM   = 18'b000000000100000000,
    S_APPLY  = 18'b000000001000000000,
    S_INS    = 18'b000000010000000000,
    S_PUT    = 18'b000000100000000000,
    S_NEWEND = 18'b000001000000000000,
    S_FIX    = 18'b000010000000000000,
    S_FIX2   = 18'b000100000000000000,
    S_REL    = 18'b001000000000000000,
    S_DONE   = 18'b010000000000000000,
    S_SPARE  = 18'b100000000000000000
  } state_e;

endpackage
`default_nettype wire

>>> hdl/tcp_segment_reassembler.sv
// Top level of the TCP segment reassembler: hold table, shared adder and sequencer.
// Flow: an accepted segment passes the extend, end and find states to the check, which
// rejects it or goes on to the discard scan, trim, insert and release; find, the discard
// scan and the insert shift walk held entries, and each discard or release shifts the
// entries behind it. One segment is taken at a time; output stalls hold the sequencer.
// Reset: window 65535, expected sequence 0, hold table empty, session open.
`default_nettype none
module tcp_segment_reassembler #(
  parameter int unsigned HOLD_DEPTH = 16,
  parameter int unsigned TAG_BITS   = 8,
  localparam int unsigned IDW = ((50 + TAG_BITS + 7) / 8) * 8,
  localparam int unsigned ODW = ((99 + TAG_BITS + 7) / 8) * 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // seq_low[31:0], seg_length, fin_flag, rst_flag, buffer_tag
  input  wire logic [IDW-1:0]                  s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // out_tag, out_seq, trim_bytes, out_length, out_fin, out_rst, closed
  output logic [ODW-1:0]                       m_axis_tdata,
  // kind
  output logic [2:0]                           m_axis_tuser,
  output logic                                 m_axis_tlast,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [tsr_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [31:0]                     cfg_data_i
);

  localparam int unsigned AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int unsigned CW = $clog2(HOLD_DEPTH + 1);
  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic [CW-1:0] FULL_CNT = CW'(HOLD_DEPTH);

  tsr_pkg::state_e state_q, state_d;

  logic [29:0] win_q, win_d;
  logic [63:0] exp_q, exp_d;
  logic        closed_q, closed_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic [63:0]         hs_q [HOLD_DEPTH];
  logic [15:0]         hl_q [HOLD_DEPTH];
  logic [15:0]         ht_q [HOLD_DEPTH];
  logic [1:0]          hf_q [HOLD_DEPTH];
  logic [TAG_BITS-1:0] hg_q [HOLD_DEPTH];

  logic [31:0] diff_q, diff_d;
  logic [63:0] sq_q, sq_d, end_q, end_d, bnd_q, bnd_d;
  logic [15:0] ln_q, ln_d, trim_q, trim_d;
  logic [1:0]  fl_q, fl_d;
  logic [TAG_BITS-1:0] tg_q, tg_d;
  logic        pok_q, pok_d, relm_q, relm_d;
  logic [CW-1:0] q_q, q_d, i_q, i_d, k_q, k_d;

  logic                mv_q;
  tsr_pkg::kind_e      mk_q;
  logic [TAG_BITS-1:0] mg_q;
  logic [63:0]         ms_q;
  logic [15:0]         mt_q, ml_q;
  logic [1:0]          mf_q;
  logic                mc_q, mlast_q;

  logic                emit, e_closed, e_last;
  tsr_pkg::kind_e      e_kind;
  logic [TAG_BITS-1:0] e_tag;
  logic [63:0]         e_seq;
  logic [15:0]         e_trim, e_len;
  logic [1:0]          e_flags;

  logic [AW-1:0]       rd_idx, wr_idx;
  logic [63:0]         rd_seq;
  logic [15:0]         rd_len, rd_trim;
  logic [1:0]          rd_flags;
  logic [TAG_BITS-1:0] rd_tag;
  logic                wr_en;
  logic [63:0]         w_seq;
  logic [15:0]         w_len, w_trim;
  logic [1:0]          w_flags;
  logic [TAG_BITS-1:0] w_tag;

  logic [63:0] alu_a, alu_b, alu_y;
  logic        alu_sub;

  logic        out_free, in_acc, cfg_acc;
  logic [CW-1:0] i_m1, k_p1, k_m1, q_p1;
  logic [63:0] bound_w;
  logic        below_w, above_w, cover_w, full_w;
  logic [16:0] tsum;

  assign out_free      = !mv_q || m_axis_tready;
  assign s_axis_tready = (state_q == tsr_pkg::S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == tsr_pkg::S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;

  assign i_m1 = i_q - ONE;
  assign k_p1 = k_q + ONE;
  assign k_m1 = k_q - ONE;
  assign q_p1 = q_q + ONE;

  assign rd_seq   = hs_q[rd_idx];
  assign rd_len   = hl_q[rd_idx];
  assign rd_trim  = ht_q[rd_idx];
  assign rd_flags = hf_q[rd_idx];
  assign rd_tag   = hg_q[rd_idx];

  assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + {63'd0, alu_sub};

  assign bound_w = pok_q ? bnd_q : exp_q;
  assign below_w = (sq_q < exp_q) && (end_q <= exp_q);
  assign above_w = !alu_y[63] && (alu_y > {34'd0, win_q});
  assign cover_w = pok_q && (sq_q < bnd_q) && (end_q <= bnd_q);
  assign full_w  = (cnt_q == FULL_CNT);
  assign tsum    = {1'b0, rd_trim} + {1'b0, trim_q};

  always_comb begin
    state_d = state_q;
    win_d = win_q; exp_d = exp_q; closed_d = closed_q; cnt_d = cnt_q;
    diff_d = diff_q; sq_d = sq_q; end_d = end_q; bnd_d = bnd_q;
    ln_d = ln_q; trim_d = trim_q; fl_d = fl_q; tg_d = tg_q;
    pok_d = pok_q; relm_d = relm_q; q_d = q_q; i_d = i_q; k_d = k_q;
    emit = 1'b0; e_kind = tsr_pkg::KIND_DONE; e_tag = tg_q; e_seq = sq_q;
    e_trim = 16'd0; e_len = ln_q; e_flags = fl_q; e_closed = closed_q; e_last = 1'b0;
    rd_idx = '0; wr_en = 1'b0; wr_idx = '0;
    w_seq = rd_seq; w_len = rd_len; w_trim = rd_trim; w_flags = rd_flags; w_tag = rd_tag;
    alu_a = sq_q; alu_b = 64'd0; alu_sub = 1'b0;

    if (cfg_acc) begin
      unique case (cfg_index_i)
        tsr_pkg::CFG_WINDOW_SIZE: win_d = cfg_data_i[29:0];
        tsr_pkg::CFG_START_SEQ: begin
          exp_d = {32'd0, cfg_data_i & tsr_pkg::LOW32_MASK};
          cnt_d = '0;
          closed_d = 1'b0;
        end
        default: ;
      endcase
    end

    unique case (state_q)
      tsr_pkg::S_IDLE: begin
        if (in_acc) begin
          diff_d = s_axis_tdata[31:0] - exp_q[31:0];
          ln_d = s_axis_tdata[47:32];
          fl_d = s_axis_tdata[49:48];
          tg_d = s_axis_tdata[50 +: TAG_BITS];
          state_d = tsr_pkg::S_EXT;
        end
      end
      tsr_pkg::S_EXT: begin
        alu_a = exp_q;
        alu_b = {{32{diff_q[31]}}, diff_q};
        sq_d = alu_y;
        state_d = tsr_pkg::S_END;
      end
      tsr_pkg::S_END: begin
        alu_b = {48'd0, ln_q};
        end_d = alu_y;
        i_d = cnt_q;
        pok_d = 1'b0;
        q_d = '0;
        state_d = tsr_pkg::S_FIND;
      end
      tsr_pkg::S_FIND: begin
        rd_idx = i_m1[AW-1:0];
        if (i_q == '0) begin
          state_d = tsr_pkg::S_CHECK;
        end else if (rd_seq >= sq_q) begin
          i_d = i_m1;
        end else begin
          pok_d = 1'b1;
          q_d = i_q;
          state_d = tsr_pkg::S_BOUND;
        end
      end
      tsr_pkg::S_BOUND: begin
        rd_idx = i_m1[AW-1:0];
        alu_a = rd_seq;
        alu_b = {48'd0, rd_len};
        bnd_d = alu_y;
        state_d = tsr_pkg::S_CHECK;
      end
      tsr_pkg::S_CHECK: begin
        alu_a = sq_q;
        alu_b = exp_q;
        alu_sub = 1'b1;
        if (below_w || above_w || cover_w || full_w) begin
          if (out_free) begin
            emit = 1'b1;
            if (below_w) e_kind = tsr_pkg::KIND_BELOW;
            else if (above_w) e_kind = tsr_pkg::KIND_ABOVE;
            else if (cover_w) e_kind = tsr_pkg::KIND_COVERED;
            else e_kind = tsr_pkg::KIND_FULL;
            state_d = tsr_pkg::S_DONE;
          end
        end else begin
          i_d = cnt_q;
          state_d = tsr_pkg::S_DISC;
        end
      end
      tsr_pkg::S_DISC: begin
        rd_idx = i_m1[AW-1:0];
        alu_a = rd_seq;
        alu_b = {48'd0, rd_len};
        if (i_q > q_q) begin
          if ((rd_seq < end_q) && (alu_y <= end_q)) begin
            if (out_free) begin
              emit = 1'b1;
              e_kind = tsr_pkg::KIND_DISCARD;
              e_tag = rd_tag; e_seq = rd_seq; e_trim = rd_trim;
              e_len = rd_len; e_flags = rd_flags;
              k_d = i_m1;
              i_d = i_m1;
              relm_d = 1'b0;
              state_d = tsr_pkg::S_SHIFT;
            end
          end else begin
            i_d = i_m1;
          end
        end else begin
          state_d = tsr_pkg::S_TRIM;
        end
      end
      tsr_pkg::S_SHIFT: begin
        rd_idx = k_p1[AW-1:0];
        if (k_p1 < cnt_q) begin
          wr_en = 1'b1;
          wr_idx = k_q[AW-1:0];
          k_d = k_p1;
        end else begin
          cnt_d = cnt_q - ONE;
          state_d = relm_q ? tsr_pkg::S_REL : tsr_pkg::S_DISC;
        end
      end
      tsr_pkg::S_TRIM: begin
        alu_a = bound_w;
        alu_b = sq_q;
        alu_sub = 1'b1;
        if (sq_q >= bound_w) trim_d = 16'd0;
        else if (alu_y > {48'd0, ln_q}) trim_d = ln_q;
        else trim_d = alu_y[15:0];
        state_d = tsr_pkg::S_APPLY;
      end
      tsr_pkg::S_APPLY: begin
        alu_b = {48'd0, trim_q};
        sq_d = alu_y;
        ln_d = ln_q - trim_q;
        k_d = cnt_q;
        state_d = tsr_pkg::S_INS;
      end
      tsr_pkg::S_INS: begin
        rd_idx = k_m1[AW-1:0];
        if (k_q > q_q) begin
          wr_en = 1'b1;
          wr_idx = k_q[AW-1:0];
          k_d = k_m1;
        end else begin
          state_d = tsr_pkg::S_PUT;
        end
      end
      tsr_pkg::S_PUT: begin
        wr_en = 1'b1;
        wr_idx = q_q[AW-1:0];
        w_seq = sq_q; w_len = ln_q; w_trim = trim_q; w_flags = fl_q; w_tag = tg_q;
        cnt_d = cnt_q + ONE;
        state_d = tsr_pkg::S_NEWEND;
      end
      tsr_pkg::S_NEWEND: begin
        alu_b = {48'd0, ln_q};
        end_d = alu_y;
        state_d = (q_p1 < cnt_q) ? tsr_pkg::S_FIX : tsr_pkg::S_REL;
      end
      tsr_pkg::S_FIX: begin
        rd_idx = q_p1[AW-1:0];
        alu_a = end_q;
        alu_b = rd_seq;
        alu_sub = 1'b1;
        if (rd_seq >= end_q) trim_d = 16'd0;
        else if (alu_y > {48'd0, rd_len}) trim_d = rd_len;
        else trim_d = alu_y[15:0];
        state_d = tsr_pkg::S_FIX2;
      end
      tsr_pkg::S_FIX2: begin
        rd_idx = q_p1[AW-1:0];
        alu_a = rd_seq;
        alu_b = {48'd0, trim_q};
        wr_en = 1'b1;
        wr_idx = q_p1[AW-1:0];
        w_seq = alu_y;
        w_len = rd_len - trim_q;
        w_trim = tsum[16] ? 16'hffff : tsum[15:0];
        state_d = tsr_pkg::S_REL;
      end
      tsr_pkg::S_REL: begin
        rd_idx = '0;
        alu_a = exp_q;
        alu_b = {48'd0, rd_len};
        if ((cnt_q != '0) && (rd_seq == exp_q)) begin
          if (out_free) begin
            emit = 1'b1;
            e_kind = tsr_pkg::KIND_RELEASED;
            e_tag = rd_tag; e_seq = rd_seq; e_trim = rd_trim;
            e_len = rd_len; e_flags = rd_flags;
            e_closed = closed_q || (rd_flags != 2'b00);
            closed_d = e_closed;
            exp_d = alu_y;
            k_d = '0;
            relm_d = 1'b1;
            state_d = tsr_pkg::S_SHIFT;
          end
        end else begin
          state_d = tsr_pkg::S_DONE;
        end
      end
      tsr_pkg::S_DONE: begin
        if (out_free) begin
          emit = 1'b1;
          e_kind = tsr_pkg::KIND_DONE;
          e_seq = exp_q; e_len = 16'd0; e_flags = 2'b00; e_last = 1'b1;
          state_d = tsr_pkg::S_IDLE;
        end
      end
      default: state_d = tsr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsr_pkg::S_IDLE;
      win_q <= tsr_pkg::WINDOW_RESET;
      exp_q <= 64'd0;
      closed_q <= 1'b0;
      cnt_q <= '0;
      mv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      win_q <= win_d;
      exp_q <= exp_d;
      closed_q <= closed_d;
      cnt_q <= cnt_d;
      if (emit) mv_q <= 1'b1;
      else if (m_axis_tready) mv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d; sq_q <= sq_d; end_q <= end_d; bnd_q <= bnd_d;
    ln_q <= ln_d; trim_q <= trim_d; fl_q <= fl_d; tg_q <= tg_d;
    pok_q <= pok_d; relm_q <= relm_d; q_q <= q_d; i_q <= i_d; k_q <= k_d;
    if (emit) begin
      mk_q <= e_kind; mg_q <= e_tag; ms_q <= e_seq; mt_q <= e_trim;
      ml_q <= e_len; mf_q <= e_flags; mc_q <= e_closed; mlast_q <= e_last;
    end
    if (wr_en) begin
      hs_q[wr_idx] <= w_seq;
      hl_q[wr_idx] <= w_len;
      ht_q[wr_idx] <= w_trim;
      hf_q[wr_idx] <= w_flags;
      hg_q[wr_idx] <= w_tag;
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tuser  = mk_q;
  assign m_axis_tlast  = mlast_q;
  assign m_axis_tdata  = ODW'({mc_q, mf_q[1], mf_q[0], ml_q, mt_q, ms_q, mg_q});

endmodule
`default_nettype wire
